### design/ihg_pkg.sv
// Shared types and constants for the IPv4 header generator.
`timescale 1ns / 1ps
package ihg_pkg;

	localparam int HDR_WORDS = 10;
	localparam int WORD_W    = 16;
	localparam int IDX_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam int ADDR_W    = 32;
	localparam int TTL_W     = 8;

	localparam logic [IDX_W-1:0] LAST_IDX = 4'd9;
	localparam int               CSUM_POS = 5;

	localparam logic [3:0]        IP_VERSION = 4'd4;
	localparam logic [3:0]        IHL_WORDS  = 4'd5;
	localparam logic [7:0]        PROTO_UDP  = 8'd17;
	localparam logic [WORD_W-1:0] FLAGS_DF   = 16'h4000;

	localparam logic [TTL_W-1:0] TTL_RESET = 8'd64;

	// Request operations.
	localparam logic OP_UNFRAGMENTED = 1'b0;
	localparam logic OP_FRAGMENT     = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_ADDR     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_TO_LIVE = 2'd1;

	typedef logic [HDR_WORDS-1:0][WORD_W-1:0] hdr_t;

	// One header moving between pipeline parts.
	typedef struct packed {
		logic valid;
		hdr_t words;
	} hdr_req_t;

endpackage

### design/ihg_build.sv
// First pipeline stage: takes a request and lays out the ten header words.
`timescale 1ns / 1ps
module ihg_build (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         op,
	input  logic [31:0]                  dst_addr,
	input  logic [15:0]                  total_length,
	input  logic [7:0]                   service_type,
	input  logic [15:0]                  ident,
	input  logic [15:0]                  offset_bytes,
	input  logic                         more_frags,
	input  logic [ihg_pkg::ADDR_W-1:0]   src_addr,
	input  logic [ihg_pkg::TTL_W-1:0]    ttl,
	input  logic                         take,
	output logic                         busy,
	output ihg_pkg::hdr_req_t            hdr_out
);

	logic          valid_s1;
	ihg_pkg::hdr_t words_s1;
	ihg_pkg::hdr_t words_d;
	logic          accept;

	assign busy   = valid_s1 && !take;
	assign accept = start && !busy;

	always_comb begin
		words_d    = '0;
		words_d[0] = {ihg_pkg::IP_VERSION, ihg_pkg::IHL_WORDS, service_type};
		words_d[1] = total_length;
		if (op == ihg_pkg::OP_FRAGMENT) begin
			words_d[2] = ident;
			// Reserved and DF stay clear; the offset field is the byte offset in 8-byte units.
			words_d[3] = {2'b00, more_frags, offset_bytes[15:3]};
		end else begin
			words_d[2] = '0;
			words_d[3] = ihg_pkg::FLAGS_DF;
		end
		words_d[4] = {ttl, ihg_pkg::PROTO_UDP};
		words_d[ihg_pkg::CSUM_POS] = '0;
		words_d[6] = src_addr[31:16];
		words_d[7] = src_addr[15:0];
		words_d[8] = dst_addr[31:16];
		words_d[9] = dst_addr[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			words_s1 <= words_d;
		end
	end

	assign hdr_out.valid = valid_s1;
	assign hdr_out.words = words_s1;

endmodule

### design/ihg_csum.sv
// Checksum stages: partial sums, then the end-around-carry fold and complement.
`timescale 1ns / 1ps
module ihg_csum (
	input  logic              clk,
	input  logic              arst_n,
	input  ihg_pkg::hdr_req_t hdr_in,
	output logic              in_take,
	input  logic              out_take,
	output ihg_pkg::hdr_req_t hdr_out
);

	localparam int SUMA_W = ihg_pkg::WORD_W + 3;
	localparam int SUMB_W = ihg_pkg::WORD_W + 2;
	localparam int ACC_W  = ihg_pkg::WORD_W + 4;

	logic                        valid_s2;
	ihg_pkg::hdr_t               words_s2;
	logic [SUMA_W-1:0]           suma_s2;
	logic [SUMB_W-1:0]           sumb_s2;
	logic                        valid_s3;
	ihg_pkg::hdr_t               words_s3;
	logic                        adv_s3;
	logic [SUMA_W-1:0]           suma_d;
	logic [SUMB_W-1:0]           sumb_d;
	logic [ACC_W-1:0]            acc;
	logic [ihg_pkg::WORD_W:0]    fold1;
	logic [ihg_pkg::WORD_W-1:0]  fold2;
	ihg_pkg::hdr_t               words_d;

	assign adv_s3  = !valid_s3 || out_take;
	assign in_take = !valid_s2 || adv_s3;

	// The checksum word is zero here, so it can be left out of the sums.
	assign suma_d = {3'b000, hdr_in.words[0]} + {3'b000, hdr_in.words[1]}
		+ {3'b000, hdr_in.words[2]} + {3'b000, hdr_in.words[3]}
		+ {3'b000, hdr_in.words[4]};
	assign sumb_d = {2'b00, hdr_in.words[6]} + {2'b00, hdr_in.words[7]}
		+ {2'b00, hdr_in.words[8]} + {2'b00, hdr_in.words[9]};

	assign acc   = {1'b0, suma_s2} + {2'b00, sumb_s2};
	assign fold1 = {1'b0, acc[ihg_pkg::WORD_W-1:0]} + {13'd0, acc[ACC_W-1:ihg_pkg::WORD_W]};
	assign fold2 = fold1[ihg_pkg::WORD_W-1:0] + {15'd0, fold1[ihg_pkg::WORD_W]};

	always_comb begin
		words_d = words_s2;
		words_d[ihg_pkg::CSUM_POS] = ~fold2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s2 <= hdr_in.valid;
			end
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			words_s2 <= hdr_in.words;
			suma_s2  <= suma_d;
			sumb_s2  <= sumb_d;
		end
		if (adv_s3) begin
			words_s3 <= words_d;
		end
	end

	assign hdr_out.valid = valid_s3;
	assign hdr_out.words = words_s3;

	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !out_take |=> valid_s3 && $stable(words_s3))
		else $error("stalled header changed in the checksum stage");

endmodule

### design/ihg_emit.sv
// Word serializer: holds one finished header and sends it one word per cycle.
`timescale 1ns / 1ps
module ihg_emit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ihg_pkg::hdr_req_t             hdr_in,
	output logic                          take,
	output logic                          strobe,
	output logic [ihg_pkg::WORD_W-1:0]    header_word,
	output logic [ihg_pkg::IDX_W-1:0]     word_index,
	output logic                          last_word
);

	ihg_pkg::hdr_t                store_q;
	logic                         active_q;
	logic [ihg_pkg::IDX_W-1:0]    ptr_q;
	logic                         strobe_q;
	logic [ihg_pkg::WORD_W-1:0]   word_q;
	logic [ihg_pkg::IDX_W-1:0]    index_q;
	logic                         last_q;

	// A new header loads as the last word of the previous one leaves, so words stream gap-free.
	assign take = hdr_in.valid && (!active_q || ptr_q == ihg_pkg::LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ptr_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (active_q) begin
				if (ptr_q == ihg_pkg::LAST_IDX) begin
					ptr_q    <= '0;
					active_q <= take;
				end else begin
					ptr_q <= ptr_q + 1'b1;
				end
			end else if (take) begin
				active_q <= 1'b1;
				ptr_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			store_q <= hdr_in.words;
		end
		if (active_q) begin
			word_q  <= store_q[ptr_q];
			index_q <= ptr_q;
			last_q  <= (ptr_q == ihg_pkg::LAST_IDX);
		end
	end

	assign strobe      = strobe_q;
	assign header_word = word_q;
	assign word_index  = index_q;
	assign last_word   = last_q;

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> ptr_q <= ihg_pkg::LAST_IDX)
		else $error("word pointer beyond the header");

	a_words_follow: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !last_q |=> strobe_q && index_q == $past(index_q) + 1'b1)
		else $error("header words not sent back to back");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && last_q |-> index_q == ihg_pkg::LAST_IDX)
		else $error("last word marked at the wrong position");

endmodule

### design/ipv4_header_generator.sv
// Top level of the IPv4 header generator with configuration registers.
`timescale 1ns / 1ps
// Each request accepted (start high while busy is low) yields a 20-byte IPv4/UDP
// header as ten 16-bit words on header_word, one per cycle with strobe high, word_index
// counting 0 to 9 and last_word on the tenth. The 16-bit result port bounds the rate, as
// the serializer takes a new header only as the last word of the one before leaves; three
// more requests can wait in the build and checksum stages, and busy rises once they are
// full. Results cannot be held off by the receiver.
// Source address and TTL come from the configuration registers and should be changed
// only while no request is in flight.
module ipv4_header_generator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              op,
	input  logic [31:0]                       dst_addr,
	input  logic [15:0]                       total_length,
	input  logic [7:0]                        service_type,
	input  logic [15:0]                       ident,
	input  logic [15:0]                       offset_bytes,
	input  logic                              more_frags,
	output logic                              strobe,
	output logic [15:0]                       header_word,
	output logic [3:0]                        word_index,
	output logic                              last_word,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ihg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                       cfg_data
);

	logic [ihg_pkg::ADDR_W-1:0] src_addr_q;
	logic [ihg_pkg::TTL_W-1:0]  ttl_q;
	ihg_pkg::hdr_req_t          hdr_s1;
	ihg_pkg::hdr_req_t          hdr_s3;
	logic                       s1_take;
	logic                       s3_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_addr_q <= '0;
			ttl_q      <= ihg_pkg::TTL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ihg_pkg::CFG_SRC_ADDR:     src_addr_q <= cfg_data;
				ihg_pkg::CFG_TIME_TO_LIVE: ttl_q <= cfg_data[ihg_pkg::TTL_W-1:0];
				default: ;
			endcase
		end
	end

	ihg_build u_build (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.op           (op),
		.dst_addr     (dst_addr),
		.total_length (total_length),
		.service_type (service_type),
		.ident        (ident),
		.offset_bytes (offset_bytes),
		.more_frags   (more_frags),
		.src_addr     (src_addr_q),
		.ttl          (ttl_q),
		.take         (s1_take),
		.busy         (busy),
		.hdr_out      (hdr_s1)
	);

	ihg_csum u_csum (
		.clk      (clk),
		.arst_n   (arst_n),
		.hdr_in   (hdr_s1),
		.in_take  (s1_take),
		.out_take (s3_take),
		.hdr_out  (hdr_s3)
	);

	ihg_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.hdr_in      (hdr_s3),
		.take        (s3_take),
		.strobe      (strobe),
		.header_word (header_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

endmodule
